[rtl/lut_refresh_feedback_gate_top_macros.svh]
// ----------------------------------------------------------------------------
// LUT refresh feedback gate - assertion macros
// Shared concurrent assertion wrappers for the gate's checker.
// ----------------------------------------------------------------------------
`ifndef LUT_REFRESH_FEEDBACK_GATE_TOP_MACROS_SVH
`define LUT_REFRESH_FEEDBACK_GATE_TOP_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define LRFG_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define LRFG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/lrfg_pkg.sv]
// ----------------------------------------------------------------------------
// LUT refresh feedback gate - package
// Widths, register codes, reset values, shared types and helper functions.
// ----------------------------------------------------------------------------
package lrfg_pkg;

	localparam int MEAN_W      = 12;
	localparam int CLIP_W      = 11;
	localparam int CNT_W       = 8;
	localparam int IDX_W       = 3;
	localparam int CFG_DATA_W  = 12;
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 40;
	localparam int LPF_SHIFT   = 2;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	localparam logic [CNT_W-1:0]  RST_MIN_INTERVAL = 8'd3;
	localparam logic [CNT_W-1:0]  RST_MAX_INTERVAL = 8'd60;
	localparam logic [MEAN_W-1:0] RST_LUMA_THR     = 12'd128;
	localparam logic [CLIP_W-1:0] RST_CLIP_THR     = 11'd48;
	localparam logic [CNT_W-1:0]  RST_CONFIRM      = 8'd3;
	localparam logic [CNT_W-1:0]  RST_COOLDOWN     = 8'd10;

	typedef enum logic [IDX_W-1:0] {
		REG_MIN_INTERVAL = 3'd0,
		REG_MAX_INTERVAL = 3'd1,
		REG_LUMA_THR     = 3'd2,
		REG_CLIP_THR     = 3'd3,
		REG_CONFIRM      = 3'd4,
		REG_COOLDOWN     = 3'd5
	} reg_idx_t;

	typedef enum logic {
		KIND_OBSERVE = 1'b0,
		KIND_COMMIT  = 1'b1
	} kind_t;

	typedef struct packed {
		logic [MEAN_W-1:0] mean;
		logic [CLIP_W-1:0] high;
		logic [CLIP_W-1:0] low;
	} stats_t;

	typedef struct packed {
		logic [CNT_W-1:0]  min_interval;
		logic [CNT_W-1:0]  max_interval;
		logic [MEAN_W-1:0] luma_thr;
		logic [CLIP_W-1:0] clip_thr;
		logic [CNT_W-1:0]  confirm;
		logic [CNT_W-1:0]  cooldown;
	} cfg_t;

	// one transaction leaving the input stage this cycle
	typedef struct packed {
		logic obs;
		logic commit;
	} step_t;

	typedef struct packed {
		stats_t cur;
		stats_t nxt;
		logic   primed;
	} filt_status_t;

	// prev + floor((cur - prev) / 4); result always lies between prev and cur
	function automatic logic [MEAN_W-1:0] smooth(input logic [MEAN_W-1:0] prev,
			input logic [MEAN_W-1:0] cur);
		logic signed [MEAN_W:0] diff;
		logic signed [MEAN_W:0] step;
		logic [MEAN_W:0]        sum;
		diff = signed'({1'b0, cur}) - signed'({1'b0, prev});
		step = diff >>> LPF_SHIFT;
		sum  = {1'b0, prev} + unsigned'(step);
		return sum[MEAN_W-1:0];
	endfunction

	function automatic logic [MEAN_W-1:0] absdiff(input logic [MEAN_W-1:0] a,
			input logic [MEAN_W-1:0] b);
		return (a >= b) ? (a - b) : (b - a);
	endfunction

endpackage

[rtl/lrfg_cfg.sv]
// ----------------------------------------------------------------------------
// LUT refresh feedback gate - configuration registers
// Write-only register bank with reset defaults.
// ----------------------------------------------------------------------------
module lrfg_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [lrfg_pkg::IDX_W-1:0]    cfg_index,
	input  logic [lrfg_pkg::CFG_DATA_W-1:0] cfg_data,
	output lrfg_pkg::cfg_t                cfg
);
	import lrfg_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_interval <= RST_MIN_INTERVAL;
			cfg_q.max_interval <= RST_MAX_INTERVAL;
			cfg_q.luma_thr     <= RST_LUMA_THR;
			cfg_q.clip_thr     <= RST_CLIP_THR;
			cfg_q.confirm      <= RST_CONFIRM;
			cfg_q.cooldown     <= RST_COOLDOWN;
		end else if (cfg_valid) begin
			case (reg_idx_t'(cfg_index))
				REG_MIN_INTERVAL: cfg_q.min_interval <= cfg_data[CNT_W-1:0];
				REG_MAX_INTERVAL: cfg_q.max_interval <= cfg_data[CNT_W-1:0];
				REG_LUMA_THR:     cfg_q.luma_thr     <= cfg_data[MEAN_W-1:0];
				REG_CLIP_THR:     cfg_q.clip_thr     <= cfg_data[CLIP_W-1:0];
				REG_CONFIRM:      cfg_q.confirm      <= cfg_data[CNT_W-1:0];
				REG_COOLDOWN:     cfg_q.cooldown     <= cfg_data[CNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

endmodule

[rtl/lrfg_filter.sv]
// ----------------------------------------------------------------------------
// LUT refresh feedback gate - statistics filter
// Quarter-step low-pass on mean and clip values; first sample loads directly.
// ----------------------------------------------------------------------------
module lrfg_filter (
	input  logic                   clk,
	input  logic                   arst_n,
	input  lrfg_pkg::step_t        step,
	input  lrfg_pkg::stats_t       sample,
	output lrfg_pkg::filt_status_t status
);
	import lrfg_pkg::*;

	stats_t filt_q;
	stats_t filt_d;
	logic   primed_q;
	logic [MEAN_W-1:0] high_sm;
	logic [MEAN_W-1:0] low_sm;

	always_comb begin
		high_sm = smooth({1'b0, filt_q.high}, {1'b0, sample.high});
		low_sm  = smooth({1'b0, filt_q.low}, {1'b0, sample.low});
		if (!primed_q) begin
			filt_d = sample;
		end else begin
			filt_d.mean = smooth(filt_q.mean, sample.mean);
			filt_d.high = high_sm[CLIP_W-1:0];
			filt_d.low  = low_sm[CLIP_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filt_q   <= '0;
			primed_q <= 1'b0;
		end else if (step.obs) begin
			filt_q   <= filt_d;
			primed_q <= 1'b1;
		end
	end

	assign status.cur    = filt_q;
	assign status.nxt    = filt_d;
	assign status.primed = primed_q;

endmodule

[rtl/lrfg_gate.sv]
// ----------------------------------------------------------------------------
// LUT refresh feedback gate - refresh decision
// Commit reference, cooldown, interval and streak counters, request logic.
// ----------------------------------------------------------------------------
module lrfg_gate (
	input  logic                   clk,
	input  logic                   arst_n,
	input  lrfg_pkg::step_t        step,
	input  lrfg_pkg::filt_status_t status,
	input  lrfg_pkg::cfg_t         cfg,
	output logic                   refresh_req
);
	import lrfg_pkg::*;

	stats_t           comm_q, comm_d;
	logic             seen_q, seen_d;
	logic [CNT_W-1:0] fsc_q, fsc_d;
	logic [CNT_W-1:0] cool_q, cool_d;
	logic [CNT_W-1:0] streak_q, streak_d;
	logic [CNT_W-1:0] fsc_inc;
	logic [CNT_W-1:0] streak_inc;
	logic             over_thr;
	logic             changed;

	always_comb begin
		fsc_inc    = (fsc_q == CNT_MAX) ? fsc_q : fsc_q + 1'b1;
		streak_inc = (streak_q == CNT_MAX) ? streak_q : streak_q + 1'b1;
		over_thr   = (absdiff(status.nxt.mean, comm_q.mean) > cfg.luma_thr)
			|| (absdiff({1'b0, status.nxt.high}, {1'b0, comm_q.high}) > {1'b0, cfg.clip_thr})
			|| (absdiff({1'b0, status.nxt.low}, {1'b0, comm_q.low}) > {1'b0, cfg.clip_thr});
		// min check wins over max check
		if (fsc_inc < cfg.min_interval) begin
			changed = 1'b0;
		end else if (fsc_inc >= cfg.max_interval) begin
			changed = 1'b1;
		end else begin
			changed = over_thr;
		end

		comm_d      = comm_q;
		seen_d      = seen_q;
		fsc_d       = fsc_q;
		cool_d      = cool_q;
		streak_d    = streak_q;
		refresh_req = 1'b0;

		if (step.commit) begin
			// commit before the first sample is dropped
			if (status.primed) begin
				comm_d   = status.cur;
				seen_d   = 1'b1;
				fsc_d    = '0;
				cool_d   = cfg.cooldown;
				streak_d = '0;
			end
		end else if (step.obs) begin
			fsc_d = fsc_inc;
			if (!seen_q) begin
				refresh_req = 1'b1;
			end else if (cool_q != '0) begin
				cool_d   = cool_q - 1'b1;
				streak_d = '0;
			end else if (!changed) begin
				streak_d = '0;
			end else begin
				streak_d    = streak_inc;
				refresh_req = (streak_inc >= cfg.confirm);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			comm_q   <= '0;
			seen_q   <= 1'b0;
			fsc_q    <= '0;
			cool_q   <= '0;
			streak_q <= '0;
		end else begin
			comm_q   <= comm_d;
			seen_q   <= seen_d;
			fsc_q    <= fsc_d;
			cool_q   <= cool_d;
			streak_q <= streak_d;
		end
	end

endmodule

[rtl/lut_refresh_feedback_gate_top.sv]
// An accepted observation passes through the input register and then the result register;
// m_axis_tvalid rises when the result register loads, which waits while the result side stalls.
// Throughput: one transaction per cycle; the input register and the result
// register both advance every cycle unless the result side stalls.
// Commit transactions produce no result and never wait on the result side.
// Reset (arst_n low, asynchronous) clears all statistics, counters and flags
// and loads the configuration defaults.
// ----------------------------------------------------------------------------
// LUT refresh feedback gate - top level
// Filters per-frame luma statistics and gates LUT refresh requests.
// ----------------------------------------------------------------------------
module lut_refresh_feedback_gate_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// [11:0] mean_in, [22:12] clip_high_in, [33:23] clip_low_in, [39:34] zero
	input  logic [lrfg_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	// [0] kind: 0 observe, 1 commit
	input  logic                             s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// [0] refresh_request, [12:1] filtered_mean, [23:13] filtered_clip_high,
	// [34:24] filtered_clip_low, [39:35] zero
	output logic [lrfg_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [lrfg_pkg::IDX_W-1:0]       cfg_index,
	input  logic [lrfg_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import lrfg_pkg::*;

	localparam int PAD_W = OUT_TDATA_W - 1 - MEAN_W - 2 * CLIP_W;

	logic         valid_s1;
	kind_t        kind_s1;
	stats_t       sample_s1;
	logic         valid_s2;
	logic [OUT_TDATA_W-1:0] data_s2;

	logic         out_free;
	logic         go_s1;
	step_t        step;
	filt_status_t status;
	cfg_t         cfg;
	logic         refresh_req;

	assign out_free      = !valid_s2 || m_axis_tready;
	assign go_s1         = valid_s1 && ((kind_s1 == KIND_COMMIT) || out_free);
	assign s_axis_tready = !valid_s1 || go_s1;
	assign step.obs      = go_s1 && (kind_s1 == KIND_OBSERVE);
	assign step.commit   = go_s1 && (kind_s1 == KIND_COMMIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			kind_s1  <= KIND_OBSERVE;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
			kind_s1  <= kind_t'(s_axis_tuser);
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			sample_s1.mean <= s_axis_tdata[MEAN_W-1:0];
			sample_s1.high <= s_axis_tdata[MEAN_W +: CLIP_W];
			sample_s1.low  <= s_axis_tdata[MEAN_W+CLIP_W +: CLIP_W];
		end
	end

	lrfg_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	lrfg_filter u_filter (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.sample (sample_s1),
		.status (status)
	);

	lrfg_gate u_gate (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.status      (status),
		.cfg         (cfg),
		.refresh_req (refresh_req)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (step.obs) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step.obs) begin
			data_s2 <= {{PAD_W{1'b0}}, status.nxt.low, status.nxt.high, status.nxt.mean,
				refresh_req};
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = data_s2;

endmodule

[rtl/lrfg_checker.sv]
// ----------------------------------------------------------------------------
// LUT refresh feedback gate - port checker
// Port-level assertions on the gate, bound to the top level.
// ----------------------------------------------------------------------------
`include "lut_refresh_feedback_gate_top_macros.svh"

module lrfg_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_axis_tvalid,
	input logic                             s_axis_tready,
	input logic                             s_axis_tuser,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [lrfg_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
	import lrfg_pkg::*;

	`LRFG_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped while stalled")
	`LRFG_ASSERT_NEXT(a_out_stable, clk, arst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "result changed while stalled")
	`LRFG_ASSERT_SAME(a_in_stall_cause, clk, arst_n, !s_axis_tready, m_axis_tvalid && !m_axis_tready, "input stalled without output backpressure")
	`LRFG_ASSERT_SAME(a_out_from_obs, clk, arst_n, $rose(m_axis_tvalid), $past(s_axis_tvalid && s_axis_tready, 2) && ($past(s_axis_tuser, 2) == KIND_OBSERVE), "result without an accepted observation")

endmodule

bind lut_refresh_feedback_gate_top lrfg_checker u_lrfg_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tuser  (s_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

[tb/lut_refresh_feedback_gate_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LUT refresh feedback gate - testbench
// Drives observation and commit transactions into the gate under several
// register settings. Random gaps are inserted on the input side and random
// stalls on the result side. A tracker class mirrors the filter, the commit
// reference and the refresh counters, and checks each result in order.
// ----------------------------------------------------------------------------
module lut_refresh_feedback_gate_top_tb;
	import lrfg_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;

	typedef struct packed {
		logic   req;
		stats_t stats;
	} refresh_result_t;

	// expected behavior of the gate: filter, commit reference, counters
	class refresh_gate_tracker;
		cfg_t            regs;
		stats_t          filt;
		stats_t          comm;
		bit [CNT_W-1:0]  frames;
		bit [CNT_W-1:0]  cool_left;
		bit [CNT_W-1:0]  streak;
		bit              primed;
		bit              committed;
		refresh_result_t pending_results[$];
		int              mismatches;

		function new();
			regs.min_interval = RST_MIN_INTERVAL;
			regs.max_interval = RST_MAX_INTERVAL;
			regs.luma_thr     = RST_LUMA_THR;
			regs.clip_thr     = RST_CLIP_THR;
			regs.confirm      = RST_CONFIRM;
			regs.cooldown     = RST_COOLDOWN;
			filt       = '0;
			comm       = '0;
			frames     = '0;
			cool_left  = '0;
			streak     = '0;
			primed     = 1'b0;
			committed  = 1'b0;
			mismatches = 0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] value);
			case (idx)
				REG_MIN_INTERVAL: regs.min_interval = value[CNT_W-1:0];
				REG_MAX_INTERVAL: regs.max_interval = value[CNT_W-1:0];
				REG_LUMA_THR:     regs.luma_thr     = value[MEAN_W-1:0];
				REG_CLIP_THR:     regs.clip_thr     = value[CLIP_W-1:0];
				REG_CONFIRM:      regs.confirm      = value[CNT_W-1:0];
				REG_COOLDOWN:     regs.cooldown     = value[CNT_W-1:0];
				default: ;
			endcase
		endfunction

		// prev + floor((cur - prev) / 4)
		function bit [MEAN_W-1:0] lowpass(bit [MEAN_W-1:0] prev, bit [MEAN_W-1:0] cur);
			bit [MEAN_W:0] down;
			if (cur >= prev)
				return prev + ((cur - prev) >> LPF_SHIFT);
			down = {1'b0, prev - cur} + (MEAN_W+1)'(3);
			return prev - down[MEAN_W:LPF_SHIFT];
		endfunction

		function bit [MEAN_W-1:0] spread(bit [MEAN_W-1:0] a, bit [MEAN_W-1:0] b);
			return (a >= b) ? a - b : b - a;
		endfunction

		function void note_stats(kind_t kind, bit [MEAN_W-1:0] m, bit [CLIP_W-1:0] h,
				bit [CLIP_W-1:0] l);
			bit              changed;
			refresh_result_t r;
			if (kind == KIND_COMMIT) begin
				// commit before the filter has seen anything is dropped
				if (primed) begin
					comm      = filt;
					committed = 1'b1;
					frames    = '0;
					cool_left = regs.cooldown;
					streak    = '0;
				end
				return;
			end
			if (!primed) begin
				filt.mean = m;
				filt.high = h;
				filt.low  = l;
				primed    = 1'b1;
			end else begin
				filt.mean = lowpass(filt.mean, m);
				filt.high = CLIP_W'(lowpass({1'b0, filt.high}, {1'b0, h}));
				filt.low  = CLIP_W'(lowpass({1'b0, filt.low}, {1'b0, l}));
			end
			if (frames != CNT_MAX)
				frames++;
			if (!committed) begin
				r.req = 1'b1;
			end else if (cool_left != 0) begin
				cool_left--;
				streak = '0;
				r.req  = 1'b0;
			end else begin
				if (frames < regs.min_interval)
					changed = 1'b0;
				else if (frames >= regs.max_interval)
					changed = 1'b1;
				else
					changed = spread(filt.mean, comm.mean) > regs.luma_thr ||
						spread({1'b0, filt.high}, {1'b0, comm.high}) >
							{1'b0, regs.clip_thr} ||
						spread({1'b0, filt.low}, {1'b0, comm.low}) >
							{1'b0, regs.clip_thr};
				if (!changed) begin
					streak = '0;
					r.req  = 1'b0;
				end else begin
					if (streak != CNT_MAX)
						streak++;
					r.req = (streak >= regs.confirm);
				end
			end
			r.stats = filt;
			pending_results.push_back(r);
		endfunction

		function void flag(string what, logic [MEAN_W-1:0] want, logic [MEAN_W-1:0] got);
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
		endfunction

		function void check_refresh(logic [OUT_TDATA_W-1:0] beat);
			refresh_result_t want;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result 0x%h with nothing pending", $time, beat);
				return;
			end
			want = pending_results.pop_front();
			if (beat[0] !== want.req)
				flag("refresh_request", want.req, beat[0]);
			if (beat[12:1] !== want.stats.mean)
				flag("filtered_mean", want.stats.mean, beat[12:1]);
			if (beat[23:13] !== want.stats.high)
				flag("filtered_clip_high", want.stats.high, beat[23:13]);
			if (beat[34:24] !== want.stats.low)
				flag("filtered_clip_low", want.stats.low, beat[34:24]);
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic                   s_axis_tuser = 1'b0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b1;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [IDX_W-1:0]       cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	refresh_gate_tracker tracker = new();

	bit src_busy;
	bit sink_busy;
	int sink_hold;
	int idle_cycles;

	lut_refresh_feedback_gate_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 94)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	always @(negedge clk) begin
		if (sink_hold > 0) begin
			m_axis_tready = 1'b0;
			sink_hold--;
		end else begin
			m_axis_tready = 1'b1;
			if (sink_busy)
				sink_hold = pick_gap();
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				tracker.note_stats(kind_t'(s_axis_tuser), s_axis_tdata[11:0],
					s_axis_tdata[22:12], s_axis_tdata[33:23]);
			if (m_axis_tvalid && m_axis_tready)
				tracker.check_refresh(m_axis_tdata);
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// called at a falling edge; returns at the falling edge after the transaction
	task automatic send_item(kind_t kind, bit [MEAN_W-1:0] m, bit [CLIP_W-1:0] h,
			bit [CLIP_W-1:0] l);
		int gap;
		gap = src_busy ? pick_gap() : 0;
		if (gap > 0) begin
			s_axis_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tuser  = kind;
		s_axis_tdata  = {6'b0, l, h, m};
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	task automatic put_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] value);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = value;
		do @(posedge clk); while (!cfg_ready);
		tracker.set_reg(idx, value);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic load_regs(int min_iv, int max_iv, int luma_thr, int clip_thr,
			int confirm, int cooldown);
		put_reg(REG_MIN_INTERVAL, CFG_DATA_W'(min_iv));
		put_reg(REG_MAX_INTERVAL, CFG_DATA_W'(max_iv));
		put_reg(REG_LUMA_THR, CFG_DATA_W'(luma_thr));
		put_reg(REG_CLIP_THR, CFG_DATA_W'(clip_thr));
		put_reg(REG_CONFIRM, CFG_DATA_W'(confirm));
		put_reg(REG_COOLDOWN, CFG_DATA_W'(cooldown));
	endtask

	// commits carry no result, so keep clocking the pipe after the last pending result
	task automatic settle();
		s_axis_tvalid = 1'b0;
		while (tracker.pending_results.size() != 0)
			@(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	function automatic int jitter(int v, int hi);
		int x;
		x = v + $urandom_range(0, 12) - 6;
		if (x < 0)
			x = 0;
		if (x > hi)
			x = hi;
		return x;
	endfunction

	// scenes of steady statistics with small jitter, occasional cuts and commits
	task automatic run_traffic(int count, int commit_pct);
		bit [MEAN_W-1:0] base_m;
		bit [CLIP_W-1:0] base_h;
		bit [CLIP_W-1:0] base_l;
		int              r;
		base_m = MEAN_W'($urandom_range(0, 4095));
		base_h = CLIP_W'($urandom_range(0, 1600));
		base_l = CLIP_W'($urandom_range(0, 1600));
		repeat (count) begin
			r = $urandom_range(0, 99);
			if (r < commit_pct) begin
				send_item(KIND_COMMIT, MEAN_W'($urandom), CLIP_W'($urandom),
					CLIP_W'($urandom));
			end else if (r < commit_pct + 4) begin
				send_item(KIND_OBSERVE, MEAN_W'($urandom_range(0, 4095)),
					CLIP_W'($urandom_range(0, 2047)), CLIP_W'($urandom_range(0, 2047)));
			end else begin
				if ($urandom_range(0, 19) == 0) begin
					base_m = MEAN_W'($urandom_range(0, 4095));
					base_h = CLIP_W'($urandom_range(0, 1600));
					base_l = CLIP_W'($urandom_range(0, 1600));
				end
				send_item(KIND_OBSERVE, MEAN_W'(jitter(base_m, 4095)),
					CLIP_W'(jitter(base_h, 2047)), CLIP_W'(jitter(base_l, 2047)));
			end
		end
	endtask

	initial begin
		src_busy  = 1'b0;
		sink_busy = 1'b0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// reset defaults: early commit, filter load, extremes, cooldown
		send_item(KIND_COMMIT, 12'd100, 11'd20, 11'd20);
		send_item(KIND_OBSERVE, 12'hFFF, 11'h7FF, 11'h7FF);
		send_item(KIND_OBSERVE, 12'h000, 11'h000, 11'h000);
		send_item(KIND_OBSERVE, 12'hFFF, 11'd1600, 11'd1600);
		send_item(KIND_OBSERVE, 12'h555, 11'h2AA, 11'h555);
		send_item(KIND_OBSERVE, 12'hAAA, 11'h555, 11'h2AA);
		send_item(KIND_COMMIT, 12'hFFF, 11'h7FF, 11'h7FF);
		repeat (11)
			send_item(KIND_OBSERVE, MEAN_W'($urandom_range(0, 4095)),
				CLIP_W'($urandom_range(0, 1600)), CLIP_W'($urandom_range(0, 1600)));
		settle();

		// zero thresholds, zero confirm count, no cooldown
		load_regs(0, 255, 0, 0, 0, 0);
		send_item(KIND_COMMIT, 12'd0, 11'd0, 11'd0);
		send_item(KIND_OBSERVE, tracker.filt.mean, tracker.filt.high, tracker.filt.low);
		send_item(KIND_OBSERVE, tracker.filt.mean - 1'b1, tracker.filt.high,
			tracker.filt.low);
		send_item(KIND_OBSERVE, 12'h000, 11'h7FF, 11'h000);
		send_item(KIND_OBSERVE, 12'hFFF, 11'h000, 11'h7FF);
		settle();

		for (int ph = 1; ph <= 7; ph++) begin
			src_busy  = (ph != 1);
			sink_busy = (ph != 1 && ph != 5);
			case (ph)
				1: begin
					load_regs(RST_MIN_INTERVAL, RST_MAX_INTERVAL, RST_LUMA_THR,
						RST_CLIP_THR, RST_CONFIRM, RST_COOLDOWN);
					run_traffic(150, 8);
				end
				// minimum above maximum, top thresholds and cooldown
				2: begin
					load_regs(255, 0, 4095, 2047, 1, 255);
					run_traffic(120, 3);
				end
				// long run without commits: the interval counter saturates
				3: begin
					load_regs(0, 1, 4095, 2047, 255, 0);
					run_traffic(300, 0);
				end
				default: begin
					load_regs($urandom_range(0, 8), $urandom_range(4, 80),
						$urandom_range(0, 300), $urandom_range(0, 120),
						$urandom_range(0, 6), $urandom_range(0, 12));
					run_traffic(160, 8);
				end
			endcase
			settle();
		end

		s_axis_tvalid = 1'b0;
		while (tracker.pending_results.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
		if (tracker.mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
